FILE: rtl/core/wsme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsme_pkg
// types, constants and helpers shared by the masked frame encoder
// ----------------------------------------------------------------------------
package wsme_pkg;

  localparam logic [7:0]  HDR_TEXT_FIN = 8'h81;
  localparam logic [7:0]  LEN_MASK_BIT = 8'h80;
  localparam logic [7:0]  LEN_EXT16    = 8'hFE;
  localparam logic [15:0] SHORT_LIMIT  = 16'd126;
  localparam logic [31:0] KEY_RESET    = 32'h31EED576;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [15:0] frame_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } out_item_t;

  // per-request framing info from the frame tracker
  typedef struct packed {
    logic        first;
    logic        ext;
    logic [15:0] len;
    logic [1:0]  kpos;
    logic        fend;
  } frame_info_t;

  typedef enum logic [3:0] {
    S_HDR,
    S_LEN0,
    S_LEN1,
    S_LEN2,
    S_KEY0,
    S_KEY1,
    S_KEY2,
    S_KEY3,
    S_DATA
  } step_t;

  // key byte by position, first byte in the top bits
  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] pos);
    logic [7:0] b;
    unique case (pos)
      2'd0: b = key[31:24];
      2'd1: b = key[23:16];
      2'd2: b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/core/wsme_frame_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsme_frame_track
// tracks bytes left in the frame and the key position per payload byte
// ----------------------------------------------------------------------------
module wsme_frame_track import wsme_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [15:0] frame_length,
  output frame_info_t info
);

  logic [15:0] bytes_remaining;
  logic [15:0] bytes_remaining_next;
  logic [1:0]  key_position;
  logic [1:0]  key_position_next;
  logic [15:0] eff_len;

  always_comb begin
    eff_len = (frame_length == 16'd0) ? 16'd1 : frame_length;
    info.len = eff_len;
    info.ext = (eff_len >= SHORT_LIMIT);
    if (bytes_remaining == 16'd0) begin
      info.first = 1'b1;
      info.kpos  = 2'd0;
      info.fend  = (eff_len == 16'd1);
      bytes_remaining_next = eff_len - 16'd1;
      key_position_next    = 2'd1;
    end else begin
      info.first = 1'b0;
      info.kpos  = key_position;
      info.fend  = (bytes_remaining == 16'd1);
      bytes_remaining_next = bytes_remaining - 16'd1;
      key_position_next    = key_position + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= 16'd0;
      key_position    <= 2'd0;
    end else if (accept) begin
      bytes_remaining <= bytes_remaining_next;
      key_position    <= key_position_next;
    end
  end

endmodule

FILE: rtl/core/websocket_masked_frame_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_masked_frame_encoder_unit
// client text frame encoder: header, mask key and masked payload bytes
// ----------------------------------------------------------------------------
// Takes one payload byte per request and sends out one byte per cycle while
// result_stall is low. A byte inside a frame makes one output byte. The
// first byte of a frame (bytes remaining zero) also produces the header
// 0x81, the length byte or 0xFE plus a 16-bit big-endian length, and the
// four key bytes, so it makes 7 output bytes for lengths below 126 and 9
// otherwise. A request is held in one input register while its bytes step
// into the result register, and the next request is taken in the same
// cycle its last byte moves out. The key register is read live as bytes
// are built; write it only while the block is idle. A zero frame length is
// taken as one.
module websocket_masked_frame_encoder_unit import wsme_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  in_item_t    item,
  output logic        result_valid,
  input  logic        result_stall,
  output out_item_t   result,
  input  logic        key_we,
  input  logic [31:0] key_data
);

  // mask key register
  logic [31:0] key_reg;

  // held request
  logic        hold_valid;
  logic [7:0]  hold_data;
  frame_info_t hold_info;
  step_t       step;
  step_t       step_next;

  // framing info from tracker
  frame_info_t info;

  logic      accept;
  logic      load;
  logic      last;
  out_item_t sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_reg <= KEY_RESET;
    end else if (key_we) begin
      key_reg <= key_data;
    end
  end

  // result register free or emptying this cycle
  assign load       = hold_valid && (!result_valid || !result_stall);
  assign last       = (step == S_DATA);
  assign item_stall = hold_valid && !(load && last);
  assign accept     = item_valid && !item_stall;

  wsme_frame_track u_track (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .frame_length (item.frame_length),
    .info         (info)
  );

  // next byte step of the held request
  always_comb begin
    unique case (step)
      S_HDR:   step_next = S_LEN0;
      S_LEN0:  step_next = hold_info.ext ? S_LEN1 : S_KEY0;
      S_LEN1:  step_next = S_LEN2;
      S_LEN2:  step_next = S_KEY0;
      S_KEY0:  step_next = S_KEY1;
      S_KEY1:  step_next = S_KEY2;
      S_KEY2:  step_next = S_KEY3;
      S_KEY3:  step_next = S_DATA;
      S_DATA:  step_next = S_DATA;
      default: step_next = S_DATA;
    endcase
  end

  // byte for the current step
  always_comb begin
    sel.frame_end = 1'b0;
    unique case (step)
      S_HDR:  sel.out_byte = HDR_TEXT_FIN;
      S_LEN0: sel.out_byte = hold_info.ext ? LEN_EXT16
                                           : (LEN_MASK_BIT | {1'b0, hold_info.len[6:0]});
      S_LEN1: sel.out_byte = hold_info.len[15:8];
      S_LEN2: sel.out_byte = hold_info.len[7:0];
      S_KEY0: sel.out_byte = key_byte(key_reg, 2'd0);
      S_KEY1: sel.out_byte = key_byte(key_reg, 2'd1);
      S_KEY2: sel.out_byte = key_byte(key_reg, 2'd2);
      S_KEY3: sel.out_byte = key_byte(key_reg, 2'd3);
      S_DATA: begin
        sel.out_byte  = hold_data ^ key_byte(key_reg, hold_info.kpos);
        sel.frame_end = hold_info.fend;
      end
      default: sel.out_byte = hold_data;
    endcase
  end

  // input register and step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      step       <= S_DATA;
    end else if (accept) begin
      hold_valid <= 1'b1;
      step       <= info.first ? S_HDR : S_DATA;
    end else if (load) begin
      if (last) begin
        hold_valid <= 1'b0;
      end
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_data <= item.payload_byte;
      hold_info <= info;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= sel;
    end
  end

endmodule

FILE: rtl/core/wsme_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsme_checker
// port-level checks for the masked frame encoder
// ----------------------------------------------------------------------------
module wsme_checker import wsme_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      item_valid,
  input logic      item_stall,
  input logic      result_valid,
  input logic      result_stall,
  input out_item_t result
);

  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // a stalled request means bytes are on their way out
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid || $past(item_valid && !item_stall))
    else $error("request stalled with nothing in flight");

  // a frame end is followed by a header byte, never another frame end
  a_end_then_hdr: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && result.frame_end
      |=> !(result_valid && result.frame_end))
    else $error("two frame ends in a row");

endmodule

bind websocket_masked_frame_encoder_unit wsme_checker u_wsme_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

FILE: tb/sv/tb_websocket_masked_frame_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_websocket_masked_frame_encoder_unit
// self-checking bench for the masked client text frame encoder
// ----------------------------------------------------------------------------
// requests are queued by a stimulus process and fed by a clocked driver with
// random gaps. each accepted request runs through a local frame encoder that
// predicts header, key and masked payload bytes. a clocked monitor with
// random stalls checks every output byte in order. the mask key is rewritten
// between phases while nothing is in flight, including the extremes.
// ----------------------------------------------------------------------------
module tb_websocket_masked_frame_encoder_unit;
  import wsme_pkg::*;

  logic        clk;
  logic        rst;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  in_item_t    item         = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  out_item_t   result;
  logic        key_we       = 1'b0;
  logic [31:0] key_data     = '0;

  websocket_masked_frame_encoder_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .key_we       (key_we),
    .key_data     (key_data)
  );

  // requests waiting for the driver, and bytes the block still owes us
  in_item_t  pending_reqs[$];
  out_item_t owed_bytes[$];

  // local copy of the encoder state
  logic [31:0] enc_key   = KEY_RESET;
  logic [15:0] enc_left  = '0;
  logic [1:0]  enc_lane  = '0;

  // stimulus side frame tracking, independent of the prediction
  int unsigned gen_left  = 0;
  int unsigned long_lens[$];

  int unsigned n_queued   = 0;
  int unsigned n_req      = 0;
  int unsigned n_out      = 0;
  int unsigned n_frames   = 0;
  int unsigned n_ext      = 0;
  int unsigned n_keys     = 0;
  int unsigned mismatches = 0;

  bit          gaps_on    = 1'b0;
  bit          rx_hold    = 1'b0;
  int unsigned tx_gap     = 0;
  int unsigned rx_gap     = 0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // key byte by lane, first byte in the top bits
  function automatic logic [7:0] key_lane(input int unsigned lane);
    return enc_key[(3 - lane) * 8 +: 8];
  endfunction

  function automatic out_item_t mk_byte(input logic [7:0] b, input logic fend);
    out_item_t o;
    o.out_byte  = b;
    o.frame_end = fend;
    return o;
  endfunction

  // expected output for one accepted request
  task automatic encode_request(input in_item_t req);
    logic [15:0] len;
    if (enc_left == 0) begin
      // first byte of a frame: header, length, key
      len = req.frame_length;
      if (len == 0) len = 16'd1;  // zero length becomes a one byte frame
      owed_bytes.push_back(mk_byte(HDR_TEXT_FIN, 1'b0));
      if (len < SHORT_LIMIT) begin
        owed_bytes.push_back(mk_byte(len[7:0] | LEN_MASK_BIT, 1'b0));
      end else begin
        owed_bytes.push_back(mk_byte(LEN_EXT16, 1'b0));
        owed_bytes.push_back(mk_byte(len[15:8], 1'b0));
        owed_bytes.push_back(mk_byte(len[7:0], 1'b0));
        n_ext++;
      end
      for (int i = 0; i < 4; i++) owed_bytes.push_back(mk_byte(key_lane(i), 1'b0));
      enc_lane = '0;
      enc_left = len;
      n_frames++;
    end
    // payload byte, masked by the current lane
    enc_left = enc_left - 16'd1;
    owed_bytes.push_back(mk_byte(req.payload_byte ^ key_lane(enc_lane), enc_left == 0));
    enc_lane = enc_lane + 2'd1;
  endtask

  task automatic push_req(input logic [7:0] b, input logic [15:0] len);
    in_item_t r;
    r.payload_byte = b;
    r.frame_length = len;
    pending_reqs.push_back(r);
    n_queued++;
  endtask

  // frame length for a new random frame, mostly short
  function automatic int unsigned pick_len();
    if (long_lens.size() != 0 && $urandom_range(0, 3) == 0) return long_lens.pop_front();
    return $urandom_range(0, 12);
  endfunction

  // random requests; frames may run across phase boundaries
  task automatic queue_frames(input int unsigned n);
    int unsigned len;
    for (int unsigned i = 0; i < n; i++) begin
      if (gen_left == 0) begin
        len = pick_len();
        gen_left = (len == 0) ? 1 : len;
        push_req(8'($urandom_range(0, 255)), len[15:0]);
      end else begin
        // length field is don't-care inside a frame, so randomize it fully
        push_req(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      end
      gen_left--;
    end
  endtask

  // wait until every queued request is in and every byte is out
  task automatic drain();
    while (n_req != n_queued || owed_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_key(input logic [31:0] v);
    @(posedge clk);
    key_we   <= 1'b1;
    key_data <= v;
    @(posedge clk);
    key_we   <= 1'b0;
    enc_key = v;
    n_keys++;
  endtask

  // request driver with random gaps between requests
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      tx_gap     <= 0;
    end else if (!(item_valid && item_stall)) begin
      if (item_valid) begin
        encode_request(item);
        n_req++;
      end
      if (tx_gap != 0) begin
        tx_gap     <= tx_gap - 1;
        item_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        item       <= pending_reqs.pop_front();
        item_valid <= 1'b1;
        tx_gap     <= gaps_on ? $urandom_range(0, 17) : 0;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // output monitor with random stalls, plus the long hold when asked
  always @(posedge clk) begin : watch_out
    out_item_t   want;
    int unsigned gap_n;
    if (rst) begin
      result_stall <= 1'b0;
      rx_gap       <= 0;
    end else begin
      gap_n = (rx_gap != 0) ? rx_gap - 1 : 0;
      if (result_valid && !result_stall) begin
        n_out++;
        if (owed_bytes.size() == 0) begin
          if (mismatches < 10)
            $display("error: unexpected byte %02h end %0b", result.out_byte, result.frame_end);
          mismatches++;
        end else begin
          want = owed_bytes.pop_front();
          if (result.out_byte !== want.out_byte || result.frame_end !== want.frame_end) begin
            if (mismatches < 10)
              $display("error: byte %0d expected %02h end %0b, got %02h end %0b",
                       n_out, want.out_byte, want.frame_end, result.out_byte,
                       result.frame_end);
            mismatches++;
          end
        end
        gap_n = gaps_on ? $urandom_range(0, 17) : 0;
      end
      rx_gap       <= gap_n;
      result_stall <= rx_hold || (gap_n != 0);
    end
  end

  // one long receiver hold-off while requests keep coming
  initial begin
    while (n_req < 30) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (200) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // stimulus phases
  initial begin
    logic [31:0] k;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset key
    gaps_on = 1'b0;
    push_req(8'h00, 16'd0);        // zero length, one byte frame
    push_req(8'hFF, 16'd1);        // shortest frame
    push_req(8'h00, 16'd4);        // four bytes, one per key lane
    push_req(8'hFF, 16'hFFFF);     // length ignored inside a frame
    push_req(8'h5A, 16'h0000);
    push_req(8'hA5, 16'h8001);
    push_req(8'h11, 16'd6);        // lanes wrap around
    for (int i = 2; i <= 6; i++) push_req({i[3:0], i[3:0]}, 16'hFFFF);
    push_req(8'h3C, 16'd2);
    push_req(8'hC3, 16'd0);        // zero length ignored on a later byte
    drain();

    // random phases; extremes of the key first, boundary lengths somewhere
    long_lens.push_back(125);
    long_lens.push_back(126);
    for (int p = 0; n_queued < 200 || long_lens.size() != 0; p++) begin
      k = (p == 0) ? 32'h0000_0000 : (p == 1) ? 32'hFFFF_FFFF : $urandom;
      write_key(k);
      gaps_on = (p % 3 != 2);
      queue_frames($urandom_range(20, 45));
      drain();
    end

    // close the open frame, then start a maximum length frame
    write_key($urandom);
    gaps_on = 1'b1;
    queue_frames(gen_left);
    push_req(8'($urandom_range(0, 255)), 16'hFFFF);
    drain();
    repeat (20) @(posedge clk);

    if (owed_bytes.size() != 0) mismatches++;
    $display("covered %0d requests in %0d frames (%0d with 16-bit length), %0d bytes out",
             n_req, n_frames, n_ext, n_out);
    $display("%0d key writes, %0d mismatches", n_keys, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout with %0d bytes still owed", owed_bytes.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
